>>> hdl/sisdf_pkg.sv
package sisdf_pkg;

  localparam int STATS_ENTRIES = 1024;
  localparam int DENY_ENTRIES  = 256;
  localparam int QDEPTH        = 2;

  localparam int SAW = $clog2(STATS_ENTRIES);
  localparam int DAW = $clog2(DENY_ENTRIES);
  localparam int SCW = SAW + 1;
  localparam int IW  = ((SAW > DAW) ? SAW : DAW) + 1;
  localparam int QAW = $clog2(QDEPTH);
  localparam int QCW = $clog2(QDEPTH + 1);

  localparam logic [15:0] ETHER_IPV4 = 16'h0800;
  localparam logic [15:0] MIN_FRAME  = 16'd34;
  localparam logic [16:0] ETH_HDR    = 17'd14;
  localparam logic [16:0] TCP_HDR    = 17'd20;
  localparam logic [7:0]  PROTO_TCP  = 8'd6;
  localparam logic [3:0]  MIN_IHL    = 4'd5;

  typedef enum logic [1:0] {
    OP_FRAME   = 2'd0,
    OP_INSTALL = 2'd1,
    OP_REMOVE  = 2'd2,
    OP_QUERY   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2
  } status_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] key;
    logic        qual;
    logic        syn;
    logic [63:0] now;
    logic [63:0] expiry;
  } cmd_t;

endpackage

>>> hdl/sisdf_ifs.sv
interface sisdf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [31:0] source_addr;
  logic [15:0] frame_bytes;
  logic [15:0] ether_kind;
  logic [7:0]  ip_proto;
  logic [3:0]  ip_header_words;
  logic        syn_flag;
  logic        ack_flag;
  logic [63:0] now_time;
  logic [63:0] expiry_time;
  modport source(output valid, opcode, source_addr, frame_bytes, ether_kind, ip_proto,
                 ip_header_words, syn_flag, ack_flag, now_time, expiry_time, input ready);
  modport sink(input valid, opcode, source_addr, frame_bytes, ether_kind, ip_proto,
               ip_header_words, syn_flag, ack_flag, now_time, expiry_time, output ready);
endinterface

interface sisdf_out_if;
  logic        valid;
  logic        ready;
  logic        drop_frame;
  logic [1:0]  status;
  logic [63:0] packet_total;
  logic [63:0] syn_total;
  logic [63:0] drop_total;
  modport source(output valid, drop_frame, status, packet_total, syn_total, drop_total,
                 input ready);
  modport sink(input valid, drop_frame, status, packet_total, syn_total, drop_total,
               output ready);
endinterface

>>> hdl/sisdf_front.sv
module sisdf_front import sisdf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  sisdf_in_if.sink   in_ch,
  output cmd_t       q_cmd,
  output logic       q_valid,
  input  logic       q_ready
);

  cmd_t           ent_r [QDEPTH];
  logic [QAW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QCW-1:0] cnt_r, cnt_nxt;
  cmd_t           cls;
  logic [16:0]    hdr_end;
  logic           push, pop;

  assign in_ch.ready = cnt_r != QCW'(QDEPTH);
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = cnt_r != '0;
  assign pop         = q_valid && q_ready;
  assign q_cmd       = ent_r[rp_r];

  assign hdr_end = ETH_HDR + {11'd0, in_ch.ip_header_words, 2'b00} + TCP_HDR;

  always_comb begin
    cls.op     = op_t'(in_ch.opcode);
    cls.key    = in_ch.source_addr;
    cls.qual   = (in_ch.ether_kind == ETHER_IPV4) && (in_ch.frame_bytes >= MIN_FRAME);
    cls.syn    = (in_ch.ip_proto == PROTO_TCP) && (in_ch.ip_header_words >= MIN_IHL) &&
                 (hdr_end <= {1'b0, in_ch.frame_bytes}) && in_ch.syn_flag && !in_ch.ack_flag;
    cls.now    = in_ch.now_time;
    cls.expiry = in_ch.expiry_time;
  end

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == QAW'(QDEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (pop) begin
      rp_nxt = (rp_r == QAW'(QDEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= cls;
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCW'(QDEPTH)) else $error("queue count overflow");
  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> cnt_r == $past(cnt_r) + 1'b1) else $error("push lost");
  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    pop && !push |=> cnt_r == $past(cnt_r) - 1'b1) else $error("pop lost");
`endif

endmodule

>>> hdl/sisdf_back.sv
module sisdf_back import sisdf_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  cmd_t         q_cmd,
  input  logic         q_valid,
  output logic         q_ready,
  sisdf_out_if.source  out_ch
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_SSCAN = 9'b000000010,
    S_TOUCH = 9'b000000100,
    S_CNTRD = 9'b000001000,
    S_CNTWR = 9'b000010000,
    S_DSCAN = 9'b000100000,
    S_DRD   = 9'b001000000,
    S_DWR   = 9'b010000000,
    S_RESP  = 9'b100000000
  } state_t;

  logic [31:0] stats_key_m  [STATS_ENTRIES];
  logic [63:0] stats_pkt_m  [STATS_ENTRIES];
  logic [63:0] stats_syn_m  [STATS_ENTRIES];
  logic [SAW-1:0] stats_rank_m [STATS_ENTRIES];
  logic [31:0] deny_key_m   [DENY_ENTRIES];
  logic [63:0] deny_exp_m   [DENY_ENTRIES];
  logic [63:0] deny_drop_m  [DENY_ENTRIES];

  logic [31:0]    sk_q, dk_q;
  logic [63:0]    sp_q, ss_q, de_q, dd_q;
  logic [SAW-1:0] sr_q;
  logic [SAW-1:0] s_raddr;
  logic [DAW-1:0] d_raddr;

  logic           sk_we, sp_we, ss_we, sr_we, dk_we, de_we, dd_we;
  logic [SAW-1:0] sr_wa;
  logic [SAW-1:0] sr_wd;
  logic [63:0]    sp_wd, ss_wd, dd_wd;
  logic [DAW-1:0] d_wa;

  state_t            state_r, state_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [IW-1:0]     idx_r, idx_nxt, pidx_r, pidx_nxt;
  logic              pv_r, pv_nxt, dvq_r, dvq_nxt;
  logic [SCW-1:0]    scnt_r, scnt_nxt, limit_r, limit_nxt;
  logic              shit_r, shit_nxt;
  logic [SAW-1:0]    sslot_r, sslot_nxt, srank_r, srank_nxt, evict_r, evict_nxt;
  logic [DENY_ENTRIES-1:0] dvalid_r, dvalid_nxt;
  logic              dhit_r, dhit_nxt, dfree_r, dfree_nxt;
  logic [DAW-1:0]    dslot_r, dslot_nxt, dfslot_r, dfslot_nxt;
  logic [63:0]       dexp_r, dexp_nxt;
  logic              drop_r, drop_nxt;
  status_t           status_r, status_nxt;
  logic [63:0]       pkt_r, pkt_nxt, syn_r, syn_nxt, drops_r, drops_nxt;
  logic              issue;

  assign out_ch.valid        = state_r == S_RESP;
  assign out_ch.drop_frame   = drop_r;
  assign out_ch.status       = status_r;
  assign out_ch.packet_total = pkt_r;
  assign out_ch.syn_total    = syn_r;
  assign out_ch.drop_total   = drops_r;

  assign s_raddr = (state_r == S_CNTRD) ? sslot_r : idx_r[SAW-1:0];
  assign d_raddr = (state_r == S_DRD) ? dslot_r : idx_r[DAW-1:0];

  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    idx_nxt    = idx_r;
    pidx_nxt   = idx_r;
    pv_nxt     = 1'b0;
    dvq_nxt    = dvalid_r[idx_r[DAW-1:0]];
    scnt_nxt   = scnt_r;
    limit_nxt  = limit_r;
    shit_nxt   = shit_r;
    sslot_nxt  = sslot_r;
    srank_nxt  = srank_r;
    evict_nxt  = evict_r;
    dvalid_nxt = dvalid_r;
    dhit_nxt   = dhit_r;
    dfree_nxt  = dfree_r;
    dslot_nxt  = dslot_r;
    dfslot_nxt = dfslot_r;
    dexp_nxt   = dexp_r;
    drop_nxt   = drop_r;
    status_nxt = status_r;
    pkt_nxt    = pkt_r;
    syn_nxt    = syn_r;
    drops_nxt  = drops_r;
    q_ready    = 1'b0;
    issue      = 1'b0;
    sk_we = 1'b0; sp_we = 1'b0; ss_we = 1'b0; sr_we = 1'b0;
    dk_we = 1'b0; de_we = 1'b0; dd_we = 1'b0;
    sr_wa = pidx_r[SAW-1:0];
    sr_wd = '0;
    sp_wd = 64'd1;
    ss_wd = {63'd0, cmd_r.syn};
    dd_wd = '0;
    d_wa  = dslot_r;

    case (state_r)
      S_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          cmd_nxt    = q_cmd;
          idx_nxt    = '0;
          shit_nxt   = 1'b0;
          dhit_nxt   = 1'b0;
          dfree_nxt  = 1'b0;
          evict_nxt  = '0;
          drop_nxt   = 1'b0;
          status_nxt = ST_OK;
          pkt_nxt    = '0;
          syn_nxt    = '0;
          drops_nxt  = '0;
          case (q_cmd.op)
            OP_FRAME:   state_nxt = q_cmd.qual ? S_SSCAN : S_RESP;
            OP_QUERY:   state_nxt = S_SSCAN;
            default:    state_nxt = S_DSCAN;
          endcase
        end
      end

      S_SSCAN: begin
        issue   = idx_r < IW'(scnt_r);
        pv_nxt  = issue;
        if (issue) begin
          idx_nxt = idx_r + 1'b1;
        end
        if (pv_r) begin
          if (sk_q == cmd_r.key) begin
            shit_nxt  = 1'b1;
            sslot_nxt = pidx_r[SAW-1:0];
            srank_nxt = sr_q;
          end
          if (sr_q == SAW'(STATS_ENTRIES - 1)) begin
            evict_nxt = pidx_r[SAW-1:0];
          end
        end
        if (!issue && !pv_r) begin
          idx_nxt = '0;
          if (cmd_r.op == OP_FRAME) begin
            state_nxt = S_TOUCH;
            if (shit_r) begin
              limit_nxt = {1'b0, srank_r};
            end else if (scnt_r < SCW'(STATS_ENTRIES)) begin
              sslot_nxt = scnt_r[SAW-1:0];
              limit_nxt = SCW'(STATS_ENTRIES);
              scnt_nxt  = scnt_r + 1'b1;
            end else begin
              sslot_nxt = evict_r;
              limit_nxt = SCW'(STATS_ENTRIES);
            end
          end else begin
            state_nxt = shit_r ? S_CNTRD : S_DSCAN;
          end
        end
      end

      S_TOUCH: begin
        issue  = idx_r < IW'(scnt_r);
        pv_nxt = issue;
        if (issue) begin
          idx_nxt = idx_r + 1'b1;
        end
        if (pv_r) begin
          if (pidx_r[SAW-1:0] == sslot_r) begin
            sr_we = 1'b1;
            sr_wd = '0;
          end else if ({1'b0, sr_q} < limit_r) begin
            sr_we = 1'b1;
            sr_wd = sr_q + 1'b1;
          end
        end
        if (!issue && !pv_r) begin
          state_nxt = S_CNTRD;
        end
      end

      S_CNTRD: begin
        state_nxt = S_CNTWR;
      end

      S_CNTWR: begin
        idx_nxt   = '0;
        state_nxt = S_DSCAN;
        if (cmd_r.op == OP_FRAME) begin
          sp_we = 1'b1;
          ss_we = 1'b1;
          if (shit_r) begin
            sp_wd = sp_q + 64'd1;
            ss_wd = ss_q + {63'd0, cmd_r.syn};
          end else begin
            sk_we = 1'b1;
          end
        end else begin
          pkt_nxt = sp_q;
          syn_nxt = ss_q;
        end
      end

      S_DSCAN: begin
        issue  = idx_r < IW'(DENY_ENTRIES);
        pv_nxt = issue;
        if (issue) begin
          idx_nxt = idx_r + 1'b1;
        end
        if (pv_r) begin
          if (dvq_r && dk_q == cmd_r.key) begin
            dhit_nxt  = 1'b1;
            dslot_nxt = pidx_r[DAW-1:0];
            dexp_nxt  = de_q;
          end
          if (!dvq_r && !dfree_r) begin
            dfree_nxt  = 1'b1;
            dfslot_nxt = pidx_r[DAW-1:0];
          end
        end
        if (!issue && !pv_r) begin
          state_nxt = S_RESP;
          case (cmd_r.op)
            OP_FRAME: begin
              if (dhit_r && cmd_r.now < dexp_r) begin
                state_nxt = S_DRD;
              end
            end
            OP_INSTALL: begin
              if (dhit_r) begin
                de_we = 1'b1;
                dd_we = 1'b1;
              end else if (dfree_r) begin
                d_wa  = dfslot_r;
                dk_we = 1'b1;
                de_we = 1'b1;
                dd_we = 1'b1;
                dvalid_nxt[dfslot_r] = 1'b1;
              end else begin
                status_nxt = ST_FULL;
              end
            end
            OP_REMOVE: begin
              if (dhit_r) begin
                dvalid_nxt[dslot_r] = 1'b0;
              end else begin
                status_nxt = ST_NOTFOUND;
              end
            end
            default: begin
              if (dhit_r) begin
                state_nxt = S_DRD;
              end else if (!shit_r) begin
                status_nxt = ST_NOTFOUND;
              end
            end
          endcase
        end
      end

      S_DRD: begin
        state_nxt = S_DWR;
      end

      S_DWR: begin
        state_nxt = S_RESP;
        if (cmd_r.op == OP_FRAME) begin
          dd_we    = 1'b1;
          dd_wd    = dd_q + 64'd1;
          drop_nxt = 1'b1;
        end else begin
          drops_nxt = dd_q;
        end
      end

      S_RESP: begin
        if (out_ch.ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      pv_r     <= 1'b0;
      scnt_r   <= '0;
      dvalid_r <= '0;
    end else begin
      state_r  <= state_nxt;
      pv_r     <= pv_nxt;
      scnt_r   <= scnt_nxt;
      dvalid_r <= dvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    idx_r    <= idx_nxt;
    pidx_r   <= pidx_nxt;
    dvq_r    <= dvq_nxt;
    limit_r  <= limit_nxt;
    shit_r   <= shit_nxt;
    sslot_r  <= sslot_nxt;
    srank_r  <= srank_nxt;
    evict_r  <= evict_nxt;
    dhit_r   <= dhit_nxt;
    dfree_r  <= dfree_nxt;
    dslot_r  <= dslot_nxt;
    dfslot_r <= dfslot_nxt;
    dexp_r   <= dexp_nxt;
    drop_r   <= drop_nxt;
    status_r <= status_nxt;
    pkt_r    <= pkt_nxt;
    syn_r    <= syn_nxt;
    drops_r  <= drops_nxt;
  end

  always_ff @(posedge clk) begin
    sk_q <= stats_key_m[s_raddr];
    if (sk_we) begin
      stats_key_m[sslot_r] <= cmd_r.key;
    end
  end

  always_ff @(posedge clk) begin
    sp_q <= stats_pkt_m[s_raddr];
    if (sp_we) begin
      stats_pkt_m[sslot_r] <= sp_wd;
    end
  end

  always_ff @(posedge clk) begin
    ss_q <= stats_syn_m[s_raddr];
    if (ss_we) begin
      stats_syn_m[sslot_r] <= ss_wd;
    end
  end

  always_ff @(posedge clk) begin
    sr_q <= stats_rank_m[s_raddr];
    if (sr_we) begin
      stats_rank_m[sr_wa] <= sr_wd;
    end
  end

  always_ff @(posedge clk) begin
    dk_q <= deny_key_m[d_raddr];
    if (dk_we) begin
      deny_key_m[d_wa] <= cmd_r.key;
    end
  end

  always_ff @(posedge clk) begin
    de_q <= deny_exp_m[d_raddr];
    if (de_we) begin
      deny_exp_m[d_wa] <= cmd_r.expiry;
    end
  end

  always_ff @(posedge clk) begin
    dd_q <= deny_drop_m[d_raddr];
    if (dd_we) begin
      deny_drop_m[d_wa] <= dd_wd;
    end
  end

`ifndef NO_ASSERTIONS
  a_scnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    scnt_r <= SCW'(STATS_ENTRIES)) else $error("stats count overflow");
  a_drop_frame_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.drop_frame |-> cmd_r.op == OP_FRAME)
    else $error("drop on command");
  a_full_install_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status == ST_FULL |-> cmd_r.op == OP_INSTALL)
    else $error("full status on non-install");
  a_scnt_grows_on_frame: assert property (@(posedge clk) disable iff (!rst_n)
    scnt_r != $past(scnt_r) |-> $past(state_r) == S_SSCAN && cmd_r.op == OP_FRAME)
    else $error("stats count changed outside frame");
`endif

endmodule

>>> hdl/source_ip_stats_deny_filter.sv
// Channel  | Direction | Content
// in_ch    | in        | frame header fields or deny/query command
// out_ch   | out       | drop decision, status and counters, one per input transfer
//
// An input transfer enters a two-entry queue; the engine handles one at a time.
// Frame: linear scans of the stats table (lookup, then rank update) and of the deny table.
// Query: scan of the stats table, then of the deny table; install/remove: deny table scan
// only; non-IPv4 or short frames: no scan. Reset (rst_n, synchronous) empties both tables
// via fill count and valid bits; no clearing pass. out_ch stall holds the engine; the queue
// then fills.
module source_ip_stats_deny_filter import sisdf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  sisdf_in_if.sink    in_ch,
  sisdf_out_if.source out_ch
);

  cmd_t q_cmd;
  logic q_valid;
  logic q_ready;

  sisdf_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_cmd   (q_cmd),
    .q_valid (q_valid),
    .q_ready (q_ready)
  );

  sisdf_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_cmd   (q_cmd),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .out_ch  (out_ch)
  );

endmodule

>>> sim/source_ip_stats_deny_filter_tb.sv
`timescale 1ns / 100ps

module source_ip_stats_deny_filter_tb;
  import sisdf_pkg::*;

  typedef struct {
    op_t         op;
    logic [31:0] key;
    logic [15:0] len;
    logic [15:0] kind;
    logic [7:0]  proto;
    logic [3:0]  ihl;
    logic        syn;
    logic        ack;
    logic [63:0] now;
    logic [63:0] expiry;
  } request_t;

  typedef struct {
    logic        drop;
    status_t     status;
    logic [63:0] packets;
    logic [63:0] syns;
    logic [63:0] drops;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n;
  sisdf_in_if  in_ch ();
  sisdf_out_if out_ch ();

  source_ip_stats_deny_filter uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // shadow tables
  bit          st_valid [STATS_ENTRIES];
  logic [31:0] st_key   [STATS_ENTRIES];
  logic [63:0] st_pkts  [STATS_ENTRIES];
  logic [63:0] st_syns  [STATS_ENTRIES];
  int          st_rank  [STATS_ENTRIES];
  int          st_count;
  bit          dn_valid [DENY_ENTRIES];
  logic [31:0] dn_key   [DENY_ENTRIES];
  logic [63:0] dn_expiry[DENY_ENTRIES];
  logic [63:0] dn_drops [DENY_ENTRIES];

  verdict_t    pending_verdicts[$];
  int          errors;
  bit          quiet;
  int          stall_left;
  logic [63:0] clock_ns;
  logic [31:0] key_pool[24];

  always #5 clk = ~clk;

  initial begin
    #200_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic int stats_lookup(logic [31:0] key);
    for (int i = 0; i < STATS_ENTRIES; i++)
      if (st_valid[i] && st_key[i] == key) return i;
    return -1;
  endfunction

  function automatic int deny_lookup(logic [31:0] key);
    for (int i = 0; i < DENY_ENTRIES; i++)
      if (dn_valid[i] && dn_key[i] == key) return i;
    return -1;
  endfunction

  function automatic void make_recent(int slot, int limit);
    for (int i = 0; i < STATS_ENTRIES; i++)
      if (i != slot && st_valid[i] && st_rank[i] < limit) st_rank[i]++;
    st_rank[slot] = 0;
  endfunction

  function automatic verdict_t filter_verdict(request_t r);
    verdict_t v;
    int s;
    int d;
    bit syn_hit;
    v = '{drop: 1'b0, status: ST_OK, packets: '0, syns: '0, drops: '0};
    case (r.op)
      OP_FRAME: begin
        if (r.kind == ETHER_IPV4 && r.len >= MIN_FRAME) begin
          syn_hit = r.proto == PROTO_TCP && r.ihl >= MIN_IHL &&
                    (17'd14 + 17'(r.ihl) * 17'd4 + 17'd20) <= 17'(r.len) && r.syn && !r.ack;
          s = stats_lookup(r.key);
          if (s >= 0) begin
            st_pkts[s]++;
            if (syn_hit) st_syns[s]++;
            make_recent(s, st_rank[s]);
          end else begin
            if (st_count < STATS_ENTRIES) begin
              for (s = 0; s < STATS_ENTRIES; s++)
                if (!st_valid[s]) break;
              st_valid[s] = 1'b1;
              st_count++;
            end else begin
              s = 0;
              for (int i = 0; i < STATS_ENTRIES; i++)
                if (st_rank[i] == STATS_ENTRIES - 1) s = i;
            end
            st_key[s]  = r.key;
            st_pkts[s] = 64'd1;
            st_syns[s] = {63'd0, syn_hit};
            make_recent(s, STATS_ENTRIES);
          end
          d = deny_lookup(r.key);
          if (d >= 0 && r.now < dn_expiry[d]) begin
            dn_drops[d]++;
            v.drop = 1'b1;
          end
        end
      end
      OP_INSTALL: begin
        d = deny_lookup(r.key);
        if (d < 0) begin
          for (d = 0; d < DENY_ENTRIES; d++)
            if (!dn_valid[d]) break;
          if (d == DENY_ENTRIES) begin
            v.status = ST_FULL;
            return v;
          end
          dn_valid[d] = 1'b1;
          dn_key[d]   = r.key;
        end
        dn_expiry[d] = r.expiry;
        dn_drops[d]  = '0;
      end
      OP_REMOVE: begin
        d = deny_lookup(r.key);
        if (d < 0) v.status = ST_NOTFOUND;
        else dn_valid[d] = 1'b0;
      end
      default: begin
        s = stats_lookup(r.key);
        d = deny_lookup(r.key);
        if (s >= 0) begin
          v.packets = st_pkts[s];
          v.syns    = st_syns[s];
        end
        if (d >= 0) v.drops = dn_drops[d];
        if (s < 0 && d < 0) v.status = ST_NOTFOUND;
      end
    endcase
    return v;
  endfunction

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_request(request_t r);
    int gap;
    in_ch.valid           <= 1'b1;
    in_ch.opcode          <= r.op;
    in_ch.source_addr     <= r.key;
    in_ch.frame_bytes     <= r.len;
    in_ch.ether_kind      <= r.kind;
    in_ch.ip_proto        <= r.proto;
    in_ch.ip_header_words <= r.ihl;
    in_ch.syn_flag        <= r.syn;
    in_ch.ack_flag        <= r.ack;
    in_ch.now_time        <= r.now;
    in_ch.expiry_time     <= r.expiry;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_verdicts.push_back(filter_verdict(r));
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic request_t noise_request(op_t op, logic [31:0] key);
    request_t r;
    r.op     = op;
    r.key    = key;
    r.len    = 16'($urandom);
    r.kind   = 16'($urandom);
    r.proto  = 8'($urandom);
    r.ihl    = 4'($urandom);
    r.syn    = 1'($urandom);
    r.ack    = 1'($urandom);
    r.now    = {$urandom, $urandom};
    r.expiry = {$urandom, $urandom};
    return r;
  endfunction

  function automatic request_t frame(logic [31:0] key, logic [15:0] len, logic [7:0] proto,
                                     logic [3:0] ihl, logic syn, logic ack, logic [63:0] now);
    request_t r;
    r       = noise_request(OP_FRAME, key);
    r.kind  = ETHER_IPV4;
    r.len   = len;
    r.proto = proto;
    r.ihl   = ihl;
    r.syn   = syn;
    r.ack   = ack;
    r.now   = now;
    return r;
  endfunction

  function automatic request_t command(op_t op, logic [31:0] key, logic [63:0] expiry);
    request_t r;
    r        = noise_request(op, key);
    r.expiry = expiry;
    return r;
  endfunction

  always @(posedge clk) begin
    verdict_t e;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_verdicts.size() == 0) begin
          $display("%0t: result with nothing expected", $time);
          errors++;
        end else begin
          e = pending_verdicts.pop_front();
          if (out_ch.drop_frame !== e.drop) begin
            $display("%0t: drop_frame exp %0d got %0d", $time, e.drop, out_ch.drop_frame);
            errors++;
          end
          if (out_ch.status !== e.status) begin
            $display("%0t: status exp %0d got %0d", $time, e.status, out_ch.status);
            errors++;
          end
          if (out_ch.packet_total !== e.packets) begin
            $display("%0t: packet_total exp %0h got %0h", $time, e.packets,
                     out_ch.packet_total);
            errors++;
          end
          if (out_ch.syn_total !== e.syns) begin
            $display("%0t: syn_total exp %0h got %0h", $time, e.syns, out_ch.syn_total);
            errors++;
          end
          if (out_ch.drop_total !== e.drops) begin
            $display("%0t: drop_total exp %0h got %0h", $time, e.drops, out_ch.drop_total);
            errors++;
          end
        end
      end
      if (quiet) begin
        out_ch.ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if ($urandom_range(0, 9) == 0) begin
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic test_directed();
    send_request(command(OP_QUERY, 32'h0, 64'h0));
    send_request(command(OP_REMOVE, 32'hFFFF_FFFF, 64'h0));
    send_request(command(OP_INSTALL, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF));
    send_request(frame(32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 4'hF, 1'b1, 1'b0, 64'hFFFF_FFFF_FFFF_FFFE));
    send_request(frame(32'hFFFF_FFFF, 16'd34, 8'd6, 4'd5, 1'b1, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF));
    send_request(command(OP_QUERY, 32'hFFFF_FFFF, 64'h0));
    // not IPv4, too short
    send_request(command(OP_FRAME, 32'h0, 64'h0));
    send_request(frame(32'h0, 16'd33, 8'd6, 4'd5, 1'b1, 1'b0, 64'h0));
    // SYN bound: 54 bytes needed at IHL 5
    send_request(frame(32'h1, 16'd53, 8'd6, 4'd5, 1'b1, 1'b0, 64'h0));
    send_request(frame(32'h1, 16'd54, 8'd6, 4'd5, 1'b1, 1'b0, 64'h0));
    send_request(frame(32'h1, 16'hFFFF, 8'd6, 4'd4, 1'b1, 1'b0, 64'h0));
    send_request(frame(32'h1, 16'hFFFF, 8'd6, 4'hF, 1'b1, 1'b1, 64'h0));
    send_request(frame(32'h1, 16'hFFFF, 8'd17, 4'd5, 1'b1, 1'b0, 64'h0));
    send_request(frame(32'h1, 16'd94, 8'd6, 4'hF, 1'b1, 1'b0, 64'h0));
    send_request(command(OP_QUERY, 32'h1, 64'h0));
    // expiry equal to now passes, one past drops
    send_request(command(OP_INSTALL, 32'h1, 64'd1000));
    send_request(frame(32'h1, 16'd60, 8'd6, 4'd5, 1'b0, 1'b0, 64'd1000));
    send_request(frame(32'h1, 16'd60, 8'd6, 4'd5, 1'b0, 1'b0, 64'd999));
    send_request(command(OP_QUERY, 32'h1, 64'h0));
    send_request(command(OP_INSTALL, 32'h1, 64'd5000));
    send_request(command(OP_QUERY, 32'h1, 64'h0));
    send_request(command(OP_REMOVE, 32'h1, 64'h0));
    send_request(command(OP_REMOVE, 32'h1, 64'h0));
    send_request(command(OP_QUERY, 32'h1, 64'h0));
  endtask

  task automatic test_deny_full();
    for (int i = 0; i <= DENY_ENTRIES; i++)
      send_request(command(OP_INSTALL, 32'hD000_0000 + i, 64'd1 << (i % 64)));
    send_request(command(OP_INSTALL, 32'hD000_0000, 64'd77));
    send_request(command(OP_REMOVE, 32'hD000_0005, 64'h0));
    send_request(command(OP_INSTALL, 32'hD000_1000, 64'd77));
    for (int i = 0; i <= DENY_ENTRIES; i++)
      send_request(command(OP_REMOVE, 32'hD000_0000 + i, 64'h0));
    send_request(command(OP_REMOVE, 32'hD000_1000, 64'h0));
  endtask

  task automatic test_random(int count);
    request_t r;
    logic [31:0] key;
    int pick;
    for (int i = 0; i < count; i++) begin
      quiet    = (i / 100) % 4 == 3;
      clock_ns = ($urandom_range(0, 49) == 0) ? {$urandom, $urandom}
                                              : clock_ns + $urandom_range(0, 300);
      key  = ($urandom_range(0, 6) == 0) ? $urandom : key_pool[$urandom_range(0, 23)];
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        r = frame(key, $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(34, 120)),
                  $urandom_range(0, 3) == 0 ? 8'($urandom) : PROTO_TCP, 4'($urandom),
                  1'($urandom), $urandom_range(0, 2) == 0, clock_ns);
        if ($urandom_range(0, 7) == 0) r.kind = 16'($urandom);
      end else if (pick < 75) begin
        case ($urandom_range(0, 3))
          0: r = command(OP_INSTALL, key, {$urandom, $urandom});
          1: r = command(OP_INSTALL, key, clock_ns);
          default: r = command(OP_INSTALL, key, clock_ns + $urandom_range(0, 4000));
        endcase
      end else if (pick < 85) begin
        r = command(OP_REMOVE, key, {$urandom, $urandom});
      end else begin
        r = command(OP_QUERY, key, {$urandom, $urandom});
      end
      send_request(r);
    end
    quiet = 1'b0;
  endtask

  initial begin
    errors          = 0;
    quiet           = 1'b0;
    stall_left      = 0;
    clock_ns        = 64'd100_000;
    rst_n           = 1'b0;
    in_ch.valid           = 1'b0;
    in_ch.opcode          = OP_FRAME;
    in_ch.source_addr     = '0;
    in_ch.frame_bytes     = '0;
    in_ch.ether_kind      = '0;
    in_ch.ip_proto        = '0;
    in_ch.ip_header_words = '0;
    in_ch.syn_flag        = 1'b0;
    in_ch.ack_flag        = 1'b0;
    in_ch.now_time        = '0;
    in_ch.expiry_time     = '0;
    foreach (st_valid[i]) st_valid[i] = 1'b0;
    foreach (dn_valid[i]) dn_valid[i] = 1'b0;
    st_count = 0;
    foreach (key_pool[i]) key_pool[i] = $urandom;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_deny_full();
    test_random(400);
    in_ch.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
